// ----- rtl/rld_pkg.sv -----
package rld_pkg;

  localparam int unsigned CNT_W = 7;
  localparam int unsigned RUN_CAP = 64;

  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_ONE   = 8'h31;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam logic [CNT_W-1:0] MAX_RUN_RST = CNT_W'(RUN_CAP);

  // one queued job: emit ch count times, last on the final one
  typedef struct packed {
    logic [7:0]       ch;
    logic [CNT_W-1:0] count;
    logic             ovf;
  } cmd_t;

endpackage

// ----- rtl/rld_in_if.sv -----
interface rld_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;

  modport source (output valid, output in_char, input ready);
  modport sink (input valid, input in_char, output ready);
endinterface

// ----- rtl/rld_out_if.sv -----
interface rld_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last;
  logic       overflow;

  modport source (output valid, output out_char, output last, output overflow, input ready);
  modport sink (input valid, input out_char, input last, input overflow, output ready);
endinterface

// ----- rtl/rld_front.sv -----
module rld_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [rld_pkg::CNT_W-1:0] cfg_wdata_i,
  rld_in_if.sink                    in_i,
  input  logic                      q_full_i,
  output logic                      push_o,
  output rld_pkg::cmd_t             cmd_o
);
  import rld_pkg::*;

  localparam int unsigned NEXT_W = CNT_W + 4;

  logic [CNT_W-1:0]  max_run_q;
  logic              in_run_q, in_run_d;
  logic              run_is_zero_q, run_is_zero_d;
  logic [CNT_W-1:0]  run_count_q, run_count_d;
  logic              digits_done_q, digits_done_d;
  logic              sat_q, sat_d;

  logic              accept;
  logic              marker;
  logic              is_digit;
  logic [7:0]        c;
  logic [CNT_W-1:0]  lim;
  logic [NEXT_W-1:0] next_cnt;
  logic [3:0]        digit;
  logic [CNT_W-1:0]  close_n;
  logic              close_ovf;

  assign in_i.ready = !q_full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign c          = in_i.in_char;
  assign marker     = (c == CHAR_PLUS) || (c == CHAR_MINUS);

  always_comb begin
    if (max_run_q == '0) begin
      lim = CNT_W'(1);
    end else if (max_run_q > CNT_W'(RUN_CAP)) begin
      lim = CNT_W'(RUN_CAP);
    end else begin
      lim = max_run_q;
    end
  end

  always_comb begin
    is_digit = c inside {[CHAR_ZERO:CHAR_NINE]};
    digit    = 4'(c - CHAR_ZERO);
    next_cnt = NEXT_W'(run_count_q) * NEXT_W'(10) + NEXT_W'(digit);
  end

  always_comb begin
    if (run_count_q > lim) begin
      close_n   = lim;
      close_ovf = 1'b1;
    end else begin
      close_n   = run_count_q;
      close_ovf = sat_q;
    end
  end

  always_comb begin
    in_run_d      = in_run_q;
    run_is_zero_d = run_is_zero_q;
    run_count_d   = run_count_q;
    digits_done_d = digits_done_q;
    sat_d         = sat_q;
    push_o        = 1'b0;
    cmd_o.ch      = c;
    cmd_o.count   = CNT_W'(1);
    cmd_o.ovf     = 1'b0;
    if (accept) begin
      if (!in_run_q) begin
        if (marker) begin
          in_run_d      = 1'b1;
          run_is_zero_d = (c == CHAR_MINUS);
          run_count_d   = '0;
          digits_done_d = 1'b0;
          sat_d         = 1'b0;
        end else begin
          push_o = 1'b1;
        end
      end else if (marker) begin
        push_o        = (close_n != '0);
        cmd_o.ch      = run_is_zero_q ? CHAR_ZERO : CHAR_ONE;
        cmd_o.count   = close_n;
        cmd_o.ovf     = close_ovf;
        in_run_d      = 1'b0;
        run_count_d   = '0;
        digits_done_d = 1'b0;
        sat_d         = 1'b0;
      end else if (!digits_done_q && is_digit) begin
        if (next_cnt > NEXT_W'(lim)) begin
          run_count_d = lim;
          sat_d       = 1'b1;
        end else begin
          run_count_d = next_cnt[CNT_W-1:0];
        end
      end else begin
        digits_done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_run_q     <= MAX_RUN_RST;
      in_run_q      <= 1'b0;
      run_is_zero_q <= 1'b0;
      run_count_q   <= '0;
      digits_done_q <= 1'b0;
      sat_q         <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_run_q <= cfg_wdata_i;
      end
      in_run_q      <= in_run_d;
      run_is_zero_q <= run_is_zero_d;
      run_count_q   <= run_count_d;
      digits_done_q <= digits_done_d;
      sat_q         <= sat_d;
    end
  end

endmodule

// ----- rtl/rld_fifo.sv -----
module rld_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  rld_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output rld_pkg::cmd_t cmd_o
);
  import rld_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_QW = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  cmd_t              mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_QW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CNT_QW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign cmd_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CNT_QW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CNT_QW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ----- rtl/rld_back.sv -----
module rld_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_empty_i,
  input  rld_pkg::cmd_t cmd_i,
  output logic          pop_o,
  rld_out_if.source     out_o
);
  import rld_pkg::*;

  logic             active_q;
  logic [7:0]       ch_q;
  logic [CNT_W-1:0] rem_q;
  logic             ovf_q;

  logic             out_valid_q;
  logic [7:0]       out_char_q;
  logic             out_last_q;
  logic             out_ovf_q;

  logic             out_load;
  logic             emit;
  logic             finishing;

  assign out_load  = !out_valid_q || out_o.ready;
  assign emit      = active_q && out_load;
  assign finishing = emit && (rem_q == CNT_W'(1));
  assign pop_o     = !q_empty_i && (!active_q || finishing);

  assign out_o.valid    = out_valid_q;
  assign out_o.out_char = out_char_q;
  assign out_o.last     = out_last_q;
  assign out_o.overflow = out_ovf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= active_q;
      end
      if (pop_o) begin
        active_q <= 1'b1;
      end else if (finishing) begin
        active_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_char_q <= ch_q;
      out_last_q <= (rem_q == CNT_W'(1));
      out_ovf_q  <= ovf_q;
    end
    if (pop_o) begin
      ch_q  <= cmd_i.ch;
      rem_q <= cmd_i.count;
      ovf_q <= cmd_i.ovf;
    end else if (emit) begin
      rem_q <= rem_q - CNT_W'(1);
    end
  end

endmodule

// ----- rtl/marker_run_length_decoder.sv -----
// Marked run-length decoder. Bytes outside a run pass through as one item each.
// '-' or '+' opens a run of '0' or '1' characters; the decimal count that follows
// is collected, other bytes are dropped, and the next '+' or '-' closes the run
// and emits the count (clamped to max_run held to 1..RUN_CAP, overflow set when
// clamped) with last on the final character. The front end takes one input item
// per cycle and posts jobs into a QUEUE_DEPTH-entry queue; the emitter drains it
// at one output item per cycle while the output is ready, and a closing marker
// yields one item per character. Input ready drops only while the queue is full.
module marker_run_length_decoder #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [rld_pkg::CNT_W-1:0] cfg_wdata_i,
  rld_in_if.sink                    in_i,
  rld_out_if.source                 out_o
);
  import rld_pkg::*;

  logic push;
  logic pop;
  logic q_full;
  logic q_empty;
  cmd_t push_cmd;
  cmd_t head_cmd;

  rld_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  rld_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .cmd_o   (head_cmd)
  );

  rld_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .cmd_i     (head_cmd),
    .pop_o     (pop),
    .out_o     (out_o)
  );

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_full) else $error("queue push while full");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_empty) else $error("queue pop while empty");

  a_job_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (push_cmd.count != '0) && (push_cmd.count <= CNT_W'(RUN_CAP)))
    else $error("queued job count out of range");

endmodule
